[rtl/core/cbdq_pkg.sv]
// ----------------------------------------------------------------------------
// cbdq_pkg: shared types and codes for the circular buffer deque
// Request and response words, controller commands, datapath status flags,
// request kinds and response status codes.
// ----------------------------------------------------------------------------
package cbdq_pkg;

  // Fixed field widths of the request and response words.
  localparam int KIND_W  = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int CAPW_W  = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DROP_FRONT = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DROP_REAR  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd8;

  // Response status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Request word.
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value_in;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [STAT_W-1:0]         status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      is_full;
  } rsp_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              push_front;
    logic              push_rear;
    logic              take_front;
    logic              take_rear;
    logic              read_front;
    logic              read_rear;
    logic              clear;
    logic [STAT_W-1:0] status;
  } cmd_t;

  // Flags from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

[rtl/core/cbdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cbdq_ctrl: request controller
// Runs the handshake on both channels and decodes each accepted request
// into datapath commands from the empty and full flags.
// ----------------------------------------------------------------------------
module cbdq_ctrl
  import cbdq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [KIND_W-1:0] kind,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  dp_status_t dp_status,
  output cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // A new request is taken unless a response is waiting and stalled.
  assign req_stall = (state == S_RESP) && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign rsp_valid = (state == S_RESP);

  // State transitions.
  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = S_RESP;
    end else if ((state == S_RESP) && !rsp_stall) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode of the accepted request.
  always_comb begin
    cmd        = '0;
    cmd.status = STAT_OK;
    cmd.load   = accept;
    if (accept) begin
      case (kind)
        KIND_PUSH_FRONT: begin
          if (dp_status.full) cmd.status = STAT_FULL;
          else cmd.push_front = 1'b1;
        end
        KIND_PUSH_REAR: begin
          if (dp_status.full) cmd.status = STAT_FULL;
          else cmd.push_rear = 1'b1;
        end
        KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_DROP_FRONT: begin
          if (dp_status.empty) begin
            cmd.status = STAT_EMPTY;
          end else begin
            cmd.read_front = (kind != KIND_DROP_FRONT);
            cmd.take_front = (kind != KIND_PEEK_FRONT);
          end
        end
        KIND_POP_REAR, KIND_PEEK_REAR, KIND_DROP_REAR: begin
          if (dp_status.empty) begin
            cmd.status = STAT_EMPTY;
          end else begin
            cmd.read_rear = (kind != KIND_DROP_REAR);
            cmd.take_rear = (kind != KIND_PEEK_REAR);
          end
        end
        KIND_CLEAR: begin
          cmd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/cbdq_datapath.sv]
// ----------------------------------------------------------------------------
// cbdq_datapath: ring store, indices and response registers
// Holds the element memory, the front and rear indices, the element count
// and the capacity register, and forms the response word.
// ----------------------------------------------------------------------------
module cbdq_datapath
  import cbdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CAPW_W-1:0] cfg_wr_data,
  input  cmd_t              cmd,
  input  logic signed [VALUE_W-1:0] value_in,
  output dp_status_t        dp_status,
  output rsp_word_t         rsp
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAPW_W) ? CW : CAPW_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IW-1:0]         front;
  logic [IW-1:0]         rear;
  logic [CW-1:0]         count;
  logic [CW-1:0]         cap;
  logic [CW-1:0]         cap_next;
  logic [CMPW-1:0]       cfg_ext;
  logic [IW-1:0]         front_dn;
  logic [IW-1:0]         front_up;
  logic [IW-1:0]         rear_dn;
  logic [IW-1:0]         rear_up;
  logic [IW-1:0]         wr_addr;
  logic [IW-1:0]         rd_addr;
  logic [STAT_W-1:0]     res_status;
  logic                  res_read;
  logic [VALUE_W-1:0]    rd_ext;

  // Index stepping with wrap at the capacity in use.
  function automatic logic [IW-1:0] step_up(logic [IW-1:0] i, logic [CW-1:0] c);
    logic [CW-1:0] inc;
    inc = CW'(i) + CW'(1);
    return (inc >= c) ? '0 : IW'(inc);
  endfunction

  function automatic logic [IW-1:0] step_down(logic [IW-1:0] i, logic [CW-1:0] c);
    return (i == '0) ? IW'(c - CW'(1)) : i - IW'(1);
  endfunction

  assign front_dn = step_down(front, cap);
  assign front_up = step_up(front, cap);
  assign rear_dn  = step_down(rear, cap);
  assign rear_up  = step_up(rear, cap);

  // Capacity write, clamped to the range one to DEPTH.
  assign cfg_ext = CMPW'(cfg_wr_data);
  always_comb begin
    if (cfg_ext == '0) begin
      cap_next = CW'(1);
    end else if (cfg_ext > CMPW'(DEPTH)) begin
      cap_next = CW'(DEPTH);
    end else begin
      cap_next = CW'(cfg_ext);
    end
  end

  // Indices, count and capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
      cap   <= CW'(DEPTH);
    end else if (cfg_wr_en) begin
      cap   <= cap_next;
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (cmd.push_front) begin
      front <= front_dn;
      count <= count + CW'(1);
    end else if (cmd.push_rear) begin
      rear  <= rear_up;
      count <= count + CW'(1);
    end else if (cmd.take_front) begin
      front <= front_up;
      count <= count - CW'(1);
    end else if (cmd.take_rear) begin
      rear  <= rear_dn;
      count <= count - CW'(1);
    end
  end

  assign dp_status.empty = (count == '0);
  assign dp_status.full  = (count >= cap);

  // Element memory with one write port and a registered read port.
  assign wr_data = DATA_WIDTH'($unsigned(value_in));
  assign wr_addr = cmd.push_front ? front_dn : rear;
  assign rd_addr = cmd.read_front ? front : rear_dn;

  always_ff @(posedge clk) begin
    if (cmd.push_front || cmd.push_rear) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read_front || cmd.read_rear) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result registers loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= cmd.status;
      res_read   <= cmd.read_front || cmd.read_rear;
    end
  end

  // Read data widened or cut to the response field.
  generate
    if (DATA_WIDTH < VALUE_W) begin : g_narrow
      assign rd_ext = VALUE_W'($signed(rd_data));
    end else begin : g_wide
      assign rd_ext = rd_data[VALUE_W-1:0];
    end
  endgenerate

  // Response word.
  assign rsp.value_out = res_read ? $signed(rd_ext) : '0;
  assign rsp.status    = res_status;
  assign rsp.occupancy = OCC_W'(count);
  assign rsp.is_empty  = (count == '0);
  assign rsp.is_full   = (count == cap);

endmodule

[rtl/core/circular_buffer_deque.sv]
// ----------------------------------------------------------------------------
// circular_buffer_deque: double-ended queue in a ring store
// Push, pop, peek and drop at either end, or clear, with one response word
// per request carrying the value read, a status and the occupancy flags.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Word
//  req       in         req_valid / req_stall   req_word_t (kind, value_in)
//  rsp       out        rsp_valid / rsp_stall   rsp_word_t (value, status, occ)
//  cfg       in         cfg_wr_en               capacity in use, 5 bits
//
// A request is accepted and its response word is valid in the next cycle;
// the memory read port registers its data for that response word.
// With no stall a new word is taken every cycle, while the previous response
// is being delivered. A stalled response holds and stalls the request side.
// Reset is synchronous; no clearing pass runs, the memory is left unwritten.
// ----------------------------------------------------------------------------
module circular_buffer_deque
  import cbdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_word_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_word_t         rsp,
  input  logic              cfg_wr_en,
  input  logic [CAPW_W-1:0] cfg_wr_data
);

  cmd_t       cmd;
  dp_status_t dp_status;

  // Handshake and request decode.
  cbdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (req.kind),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Storage, indices and response forming.
  cbdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .value_in    (req.value_in),
    .dp_status   (dp_status),
    .rsp         (rsp)
  );

endmodule
